// ===== src/tmr_pkg.sv =====
// ----------------------------------------------------------------------------
// tmr_pkg: shared types and constants of the multi-slot timer
// Slot count, index width, item kinds, sequencer states and the result word.
// ----------------------------------------------------------------------------
package tmr_pkg;

  // Number of timer slots (1 to 16)
  parameter int NUM_SLOTS = 16;
  // Bits needed to index a slot
  parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  parameter int TIME_W    = 32;

  // Item kinds
  parameter logic [2:0] KIND_SERVICE = 3'd0;
  parameter logic [2:0] KIND_START   = 3'd1;
  parameter logic [2:0] KIND_STOP    = 3'd2;
  parameter logic [2:0] KIND_PERIOD  = 3'd3;
  parameter logic [2:0] KIND_MODE    = 3'd4;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // One expiry result, before its last flag is known
  typedef struct packed {
    logic [3:0]        slot;
    logic [TIME_W-1:0] elapsed;
    logic              stopped;
  } result_t;

  // Shared unit result
  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              hit;
  } alu_res_t;

endpackage

// ===== src/tmr_ram.sv =====
// ----------------------------------------------------------------------------
// tmr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tmr_alu.sv =====
// ----------------------------------------------------------------------------
// tmr_alu: shared accumulate and compare unit
// Saturating add of the time step to one accumulator, then compare to period.
// ----------------------------------------------------------------------------
module tmr_alu (
  input  logic [tmr_pkg::TIME_W-1:0] acc,
  input  logic [tmr_pkg::TIME_W-1:0] delta,
  input  logic [tmr_pkg::TIME_W-1:0] period,
  output tmr_pkg::alu_res_t          res
);
  import tmr_pkg::*;

  logic [TIME_W:0]   wide;
  logic [TIME_W-1:0] sat;

  // Add with carry out; clamp to all ones on overflow
  assign wide = {1'b0, acc} + {1'b0, delta};
  assign sat  = wide[TIME_W] ? {TIME_W{1'b1}} : wide[TIME_W-1:0];

  assign res.sum = sat;
  assign res.hit = (sat >= period);

endmodule

// ===== src/multi_slot_software_timer_unit.sv =====
// ----------------------------------------------------------------------------
// multi_slot_software_timer_unit: table of one-shot / periodic timer slots
// Commands: start, stop, set period and set mode are accepted while idle; a
// service word after the first walks the slots, one slot per cycle through the
// shared add/compare unit unless an expiry stalls while out_ready is low, then
// flushes. No new input word is accepted until the walk and flush are done.
// Reset: clears time tracking, active, mode and period-valid flags; slot RAMs
// need no clearing pass since unwritten entries are masked by those flags.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_unit (
  input  logic                       clk,
  input  logic                       rst,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 kind,
  input  logic [3:0]                 slot,
  input  logic [tmr_pkg::TIME_W-1:0] now_ms,
  input  logic [tmr_pkg::TIME_W-1:0] period_ms,
  input  logic                       one_shot,
  // Output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3:0]                 expired_slot,
  output logic [tmr_pkg::TIME_W-1:0] elapsed_ms,
  output logic                       stopped,
  output logic                       last
);
  import tmr_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  state_t state, state_next;

  // Time tracking
  logic              time_seen;
  logic [TIME_W-1:0] previous_time;
  logic [TIME_W-1:0] delta;

  // Per-slot flags
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] mode_one_shot;
  logic [NUM_SLOTS-1:0] period_valid;

  // Walk index and result staging
  logic [SLOT_W-1:0] idx;
  logic              pend_valid;
  result_t           pend;

  // RAM ports
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              acc_we;
  logic [SLOT_W-1:0] acc_waddr;
  logic [TIME_W-1:0] acc_wdata;
  logic              per_we;
  logic [TIME_W-1:0] acc_rdata;
  logic [TIME_W-1:0] per_rdata;
  logic [TIME_W-1:0] per_val;

  // Command decode
  logic              accept;
  logic [SLOT_W-1:0] cmd_idx;
  logic              cmd_ok;

  // Walk control
  alu_res_t          alu;
  logic              expire;
  logic              out_free;
  logic              stall;
  logic              advance;

  tmr_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (acc_rdata)
  );

  tmr_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (cmd_idx),
    .wdata (period_ms),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (per_rdata)
  );

  // Never-written periods read as zero
  assign per_val = period_valid[idx] ? per_rdata : '0;

  tmr_alu u_alu (
    .acc    (acc_rdata),
    .delta  (delta),
    .period (per_val),
    .res    (alu)
  );

  assign accept   = in_valid && in_ready;
  assign cmd_idx  = SLOT_W'(slot);
  assign cmd_ok   = (32'(slot) < NUM_SLOTS);

  assign expire   = (state == ST_WALK) && active[idx] && alu.hit;
  assign out_free = !out_valid || out_ready;
  assign stall    = expire && pend_valid && !out_free;
  assign advance  = !stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_SERVICE && time_seen) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance && idx == LAST_IDX) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    acc_we    = 1'b0;
    acc_waddr = cmd_idx;
    acc_wdata = '0;
    per_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && cmd_ok) begin
          case (kind)
            KIND_START:  acc_we = !active[cmd_idx];
            KIND_PERIOD: begin
              per_we = 1'b1;
              acc_we = active[cmd_idx];
            end
            default: acc_we = 1'b0;
          endcase
        end
        if (accept && kind == KIND_SERVICE && time_seen) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      ST_WALK: begin
        acc_waddr = idx;
        acc_we    = active[idx] && advance;
        acc_wdata = alu.hit ? '0 : alu.sum;
        rd_en     = advance && (idx != LAST_IDX);
        rd_addr   = idx + SLOT_W'(1);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      time_seen     <= 1'b0;
      previous_time <= '0;
      active        <= '0;
      mode_one_shot <= '0;
      period_valid  <= '0;
      idx           <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (kind == KIND_SERVICE) begin
              previous_time <= now_ms;
              time_seen     <= 1'b1;
              delta         <= now_ms - previous_time;
              idx           <= '0;
            end else if (cmd_ok) begin
              case (kind)
                KIND_START:  active[cmd_idx] <= 1'b1;
                KIND_STOP:   active[cmd_idx] <= 1'b0;
                KIND_PERIOD: period_valid[cmd_idx] <= 1'b1;
                KIND_MODE:   mode_one_shot[cmd_idx] <= one_shot;
                default:     ;
              endcase
            end
          end
        end
        ST_WALK: begin
          if (advance) begin
            idx <= idx + SLOT_W'(1);
            if (expire) begin
              // Older pending word is now known not to be the last
              if (pend_valid) begin
                out_valid    <= 1'b1;
                expired_slot <= pend.slot;
                elapsed_ms   <= pend.elapsed;
                stopped      <= pend.stopped;
                last         <= 1'b0;
              end
              pend_valid   <= 1'b1;
              pend.slot    <= 4'(idx);
              pend.elapsed <= alu.sum;
              pend.stopped <= mode_one_shot[idx];
              if (mode_one_shot[idx]) begin
                active[idx] <= 1'b0;
              end
            end
          end
        end
        ST_FLUSH: begin
          // Final expiry of this service carries last
          if (pend_valid && out_free) begin
            out_valid    <= 1'b1;
            expired_slot <= pend.slot;
            elapsed_ms   <= pend.elapsed;
            stopped      <= pend.stopped;
            last         <= 1'b1;
            pend_valid   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
